// ----- hdl/mcpsl_pkg.sv -----
// ----------------------------------------------------------------------------
// mcpsl_pkg: shared types and constants for the motor command parser
// Character codes, result status codes, register indexes, sequencer types and
// the request/response structs of the iterative divider.
// ----------------------------------------------------------------------------
package mcpsl_pkg;

    // command layout
    localparam int MOVE_ARG_BYTES  = 8;
    localparam int POWER_ARG_BYTES = 3;
    localparam int POS_W           = 4;
    localparam int ARG_IDX_W       = $clog2(MOVE_ARG_BYTES);

    // speed scale: speeds run -100..100, magnitude needs 7 bits
    localparam int SPEED_FULL_SCALE = 100;
    localparam int CEIL_BIAS        = SPEED_FULL_SCALE - 1;
    localparam int MAG_W            = 7;

    // divider geometry
    localparam int DIVIDEND_W      = 39;
    localparam int DIVISOR_W       = 32;
    localparam int DIV_CNT_W       = 6;
    localparam int SPEED_QUO_BITS  = 7;
    localparam int TORQUE_QUO_BITS = 16;
    localparam int DELAY_QUO_BITS  = 32;

    // scaling by 1/100 through reciprocal multiplies
    // 32-bit operand: ceil(2^37 / 100), exact for every 32-bit value
    localparam logic [31:0] RECIP_100         = 32'h51EB_851F;
    localparam int          RECIP_100_SHIFT   = 37;
    // small operand below 10000: ceil(2^19 / 100)
    localparam logic [12:0] RECIP_100_SMALL   = 13'd5243;
    localparam int          RECIP_SMALL_SHIFT = 19;
    localparam int          SMALL_W           = 14;

    // register reset values
    localparam logic        RST_SMOOTH_EN   = 1'b1;
    localparam logic [7:0]  RST_SMOOTH_STEP = 8'd10;
    localparam logic [15:0] RST_TORQUE_MIN  = 16'h0000;
    localparam logic [15:0] RST_TORQUE_MAX  = 16'hFFFF;
    localparam logic [31:0] RST_DELAY_MIN   = 32'h0000_0000;
    localparam logic [31:0] RST_DELAY_MAX   = 32'h0000_FFFF;

    // ASCII codes
    localparam logic [7:0] CHAR_P     = 8'h70;
    localparam logic [7:0] CHAR_M     = 8'h6D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_E     = 8'h45;
    localparam logic [7:0] CHAR_N     = 8'h4E;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_D     = 8'h44;
    localparam logic [7:0] CHAR_I     = 8'h49;
    localparam logic [7:0] CHAR_S     = 8'h53;

    typedef enum logic [2:0] {
        STATUS_POWER     = 3'd0,
        STATUS_MOVE      = 3'd1,
        STATUS_UNKNOWN   = 3'd2,
        STATUS_BAD_POWER = 3'd3,
        STATUS_BAD_MOVE  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        CFG_SMOOTH_EN   = 3'd0,
        CFG_SMOOTH_STEP = 3'd1,
        CFG_TORQUE_MIN  = 3'd2,
        CFG_TORQUE_MAX  = 3'd3,
        CFG_DELAY_MIN   = 3'd4,
        CFG_DELAY_MAX   = 3'd5
    } cfg_idx_t;

    // quotient length of one divide
    typedef enum logic [1:0] {
        DIV_LEN_SPEED,
        DIV_LEN_TORQUE,
        DIV_LEN_DELAY
    } div_len_t;

    typedef struct packed {
        logic     start;
        div_len_t len;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PARSE,
        ST_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_SLEW,
        ST_RECIP,
        ST_REM,
        ST_SCALE,
        ST_DONE
    } state_t;

    // arithmetic step of the move sequence
    typedef enum logic [1:0] {
        OP_PREV,
        OP_TORQUE,
        OP_DELAY
    } op_t;

endpackage

// ----- hdl/mcpsl_div.sv -----
// ----------------------------------------------------------------------------
// mcpsl_div: iterative restoring divider
// One quotient bit per cycle. The caller guarantees the quotient fits in the
// selected length, so the dividend is pre-shifted and only that many
// iterations run.
// ----------------------------------------------------------------------------
module mcpsl_div
    import mcpsl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  div_req_t              req,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output div_rsp_t              rsp,
    output logic [DIVISOR_W-1:0]  quotient
);

    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  dsr_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic                  busy_reg;

    logic [DIV_CNT_W-1:0]  load_cnt;
    logic [DIVISOR_W-1:0]  load_rem;
    logic [DIVIDEND_W-1:0] load_quo;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    trial_sub;
    logic                  fits;

    // pre-shift: upper part becomes the first partial remainder
    always_comb
    begin
        case (req.len)
            DIV_LEN_SPEED:
            begin
                load_cnt = DIV_CNT_W'(SPEED_QUO_BITS);
                load_rem = DIVISOR_W'(dividend >> SPEED_QUO_BITS);
                load_quo = dividend << (DIVIDEND_W - SPEED_QUO_BITS);
            end
            DIV_LEN_TORQUE:
            begin
                load_cnt = DIV_CNT_W'(TORQUE_QUO_BITS);
                load_rem = DIVISOR_W'(dividend >> TORQUE_QUO_BITS);
                load_quo = dividend << (DIVIDEND_W - TORQUE_QUO_BITS);
            end
            default:
            begin
                load_cnt = DIV_CNT_W'(DELAY_QUO_BITS);
                load_rem = DIVISOR_W'(dividend >> DELAY_QUO_BITS);
                load_quo = dividend << (DIVIDEND_W - DELAY_QUO_BITS);
            end
        endcase
    end

    // one restoring step
    assign trial     = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign trial_sub = trial - {1'b0, dsr_reg};
    assign fits      = (trial >= {1'b0, dsr_reg});

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= load_cnt;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            else
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= load_rem;
            quo_reg <= load_quo;
            dsr_reg <= divisor;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            rem_reg <= fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = busy_reg && (cnt_reg == '0);
    assign quotient = quo_reg[DIVISOR_W-1:0];

endmodule

// ----- hdl/motor_command_parser_slew_limit.sv -----
// ----------------------------------------------------------------------------
// motor_command_parser_slew_limit: ASCII motor command parser, slew limiter
// Letter and argument bytes are stored as they are taken; power, bad-power and
// unknown-command results are registered at the edge that takes the final byte.
// Final move byte starts the sequencer; per motor, with smoothing on, a serial divide
// recovers the previous speed and the slew limit is applied, then torque and delay
// are scaled by 1/100 with reciprocal multiplies.
// Reset: registers to defaults, parser awaits a letter, stored torques zero
// and forward, no result pending.
// ----------------------------------------------------------------------------
module motor_command_parser_slew_limit
    import mcpsl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // command byte request
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    // result request
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic        power_on,
    output logic        left_reverse,
    output logic [15:0] left_torque,
    output logic [31:0] left_delay,
    output logic        right_reverse,
    output logic [15:0] right_torque,
    output logic [31:0] right_delay,
    // register write request
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam logic MOTOR_LEFT  = 1'b0;
    localparam logic MOTOR_RIGHT = 1'b1;

    typedef struct packed {
        logic       ok;
        logic [7:0] speed;
    } field_t;

    // sign plus three digits, 0..100
    function automatic field_t parse_field(input logic [7:0] sg, input logic [7:0] c2,
                                           input logic [7:0] c1, input logic [7:0] c0);
        field_t     f;
        logic       digits_ok;
        logic [9:0] v;
        logic [7:0] v8;
        digits_ok = (c2 >= CHAR_0) && (c2 <= CHAR_9) && (c1 >= CHAR_0) && (c1 <= CHAR_9)
                    && (c0 >= CHAR_0) && (c0 <= CHAR_9);
        v = 10'(c2 - CHAR_0) * 10'd100 + 10'(c1 - CHAR_0) * 10'd10 + 10'(c0 - CHAR_0);
        v8 = v[7:0];
        f.ok = ((sg == CHAR_PLUS) || (sg == CHAR_MINUS)) && digits_ok
               && (v <= 10'(SPEED_FULL_SCALE));
        f.speed = (sg == CHAR_MINUS) ? (8'd0 - v8) : v8;
        return f;
    endfunction

    // configuration
    logic        smooth_en_reg;
    logic [7:0]  smooth_step_reg;
    logic [15:0] torque_min_reg;
    logic [15:0] torque_max_reg;
    logic [31:0] delay_min_reg;
    logic [31:0] delay_max_reg;

    // parser and sequencer state
    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic              motor_reg, motor_next;
    logic [POS_W-1:0]  pos_reg;
    logic              is_move_reg;
    logic [7:0]        arg_reg [MOVE_ARG_BYTES];
    logic [15:0]       last_trq_reg [2];
    logic              last_rev_reg [2];

    // move datapath
    logic signed [7:0]     spd_reg [2];
    logic signed [7:0]     prev_reg;
    logic                  move_ok_reg;
    logic [DIVIDEND_W-1:0] prod_reg;
    logic [63-RECIP_100_SHIFT:0] qa_reg;
    logic [MAG_W-1:0]      ra_reg;
    logic [31:0]           qm_reg;
    logic                  res_rev_reg [2];
    logic [15:0]           res_trq_reg [2];
    logic [31:0]           res_dly_reg [2];

    // result register
    logic        out_valid_reg;
    status_t     status_reg;
    logic        power_on_reg;
    logic        out_rev_reg [2];
    logic [15:0] out_trq_reg [2];
    logic [31:0] out_dly_reg [2];

    // handshake and control
    logic             slot_free;
    logic [POS_W-1:0] need_last;
    logic             mid_cmd;
    logic             move_last;
    logic             is_letter;
    logic             take;
    logic             load_imm;
    logic             load_done;
    logic [POS_W-1:0] pos_m1;
    logic             word_ena;
    logic             word_dis;
    status_t          imm_status;
    field_t           fld_left, fld_right;

    // arithmetic
    logic [15:0]           span;
    logic [31:0]           dmin_eff;
    logic [31:0]           dspan;
    logic signed [7:0]     cur_spd;
    logic [7:0]            spd_neg;
    logic [MAG_W-1:0]      mag;
    logic [15:0]           tq_hi;
    logic [15:0]           tq_clamp;
    logic [DIVISOR_W-1:0]  mul_a;
    logic [MAG_W-1:0]      mul_b;
    logic [MAG_W-1:0]      mul_add;
    logic [DIVIDEND_W-1:0] mul_p;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic [DIVISOR_W-1:0]  quotient;
    div_req_t              div_req;
    div_rsp_t              div_rsp;
    logic [31:0]           recip_a;
    logic [63:0]           recip_p;
    logic [31:0]           qa_x100;
    logic [31:0]           ra_full;
    logic [26:0]           sq_p;
    logic [31:0]           scaled;
    logic [7:0]            prev_mag;
    logic signed [7:0]     prev_speed;
    logic [15:0]           torque_val;
    logic [31:0]           delay_val;
    logic signed [9:0]     cur_w, prev_w, step_w, diff_w, slew_w;
    logic signed [7:0]     slew_speed;

    // ------------------------------------------------------------------
    // derived ranges
    assign span     = (torque_max_reg > torque_min_reg) ? (torque_max_reg - torque_min_reg)
                                                        : 16'd0;
    assign dmin_eff = (delay_min_reg < delay_max_reg) ? delay_min_reg : delay_max_reg;
    assign dspan    = delay_max_reg - dmin_eff;

    // parser conditions
    assign slot_free = !out_valid_reg || out_ready;
    assign need_last = is_move_reg ? POS_W'(MOVE_ARG_BYTES) : POS_W'(POWER_ARG_BYTES);
    assign mid_cmd   = (pos_reg != '0) && (pos_reg < need_last);
    assign move_last = is_move_reg && (pos_reg == POS_W'(MOVE_ARG_BYTES));
    assign is_letter = (rx_byte == CHAR_P) || (rx_byte == CHAR_M);
    assign take      = in_valid && in_ready;
    assign pos_m1    = pos_reg - 1'b1;
    assign word_ena  = (arg_reg[0] == CHAR_E) && (arg_reg[1] == CHAR_N) && (rx_byte == CHAR_A);
    assign word_dis  = (arg_reg[0] == CHAR_D) && (arg_reg[1] == CHAR_I) && (rx_byte == CHAR_S);
    assign imm_status = (pos_reg == '0) ? STATUS_UNKNOWN
                      : ((word_ena || word_dis) ? STATUS_POWER : STATUS_BAD_POWER);

    assign fld_left  = parse_field(arg_reg[0], arg_reg[1], arg_reg[2], arg_reg[3]);
    assign fld_right = parse_field(arg_reg[4], arg_reg[5], arg_reg[6], arg_reg[7]);

    // current motor speed and magnitude
    assign cur_spd = spd_reg[motor_reg];
    assign spd_neg = 8'd0 - cur_spd;
    assign mag     = cur_spd[7] ? spd_neg[MAG_W-1:0] : cur_spd[MAG_W-1:0];

    // stored torque clamped into the torque range
    assign tq_hi    = (last_trq_reg[motor_reg] > torque_max_reg) ? torque_max_reg
                                                                 : last_trq_reg[motor_reg];
    assign tq_clamp = (tq_hi < torque_min_reg) ? torque_min_reg : tq_hi;

    // shared multiplier operands; scaling forms remainder * mag (+ bias for delay)
    always_comb
    begin
        case (op_reg)
            OP_PREV:
            begin
                mul_a   = DIVISOR_W'(tq_clamp - torque_min_reg);
                mul_b   = MAG_W'(SPEED_FULL_SCALE);
                mul_add = '0;
            end
            OP_TORQUE:
            begin
                mul_a   = DIVISOR_W'(ra_reg);
                mul_b   = mag;
                mul_add = '0;
            end
            default:
            begin
                mul_a   = DIVISOR_W'(ra_reg);
                mul_b   = mag;
                mul_add = MAG_W'(CEIL_BIAS);
            end
        endcase
    end

    assign mul_p = DIVIDEND_W'(mul_a) * DIVIDEND_W'(mul_b) + DIVIDEND_W'(mul_add);
    assign div_divisor = (op_reg == OP_PREV) ? DIVISOR_W'(span)
                                             : DIVISOR_W'(SPEED_FULL_SCALE);

    // range * mag / 100 split as (q*100 + r) * mag: q*mag + (r*mag + bias) / 100
    assign recip_a = (op_reg == OP_TORQUE) ? 32'(span) : dspan;
    assign recip_p = 64'(recip_a) * 64'(RECIP_100);
    assign qa_x100 = 32'(qa_reg) * 32'(SPEED_FULL_SCALE);
    assign ra_full = recip_a - qa_x100;
    assign sq_p    = 27'(prod_reg[SMALL_W-1:0]) * 27'(RECIP_100_SMALL);
    assign scaled  = qm_reg + 32'(sq_p[26:RECIP_SMALL_SHIFT]);

    // results of one divide or scaling
    assign prev_mag   = (span == '0) ? 8'd0 : quotient[7:0];
    assign prev_speed = last_rev_reg[motor_reg] ? $signed(8'd0 - prev_mag) : $signed(prev_mag);
    assign torque_val = (mag == '0) ? 16'd0 : (torque_min_reg + scaled[15:0]);
    assign delay_val  = delay_max_reg - scaled;

    // slew limit against the previous speed
    always_comb
    begin
        cur_w  = 10'(cur_spd);
        prev_w = 10'(prev_reg);
        step_w = $signed({2'b00, smooth_step_reg});
        diff_w = (cur_w > prev_w) ? (cur_w - prev_w) : (prev_w - cur_w);
        if (diff_w > step_w)
        begin
            slew_w = (cur_w > prev_w) ? (prev_w + step_w) : (prev_w - step_w);
        end
        else
        begin
            slew_w = cur_w;
        end
        slew_speed = $signed(slew_w[7:0]);
    end

    mcpsl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (prod_reg),
        .divisor  (div_divisor),
        .rsp      (div_rsp),
        .quotient (quotient)
    );

    // ------------------------------------------------------------------
    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        motor_next = motor_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take && move_last)
                begin
                    state_next = ST_PARSE;
                    motor_next = MOTOR_LEFT;
                end
            end
            ST_PARSE:
            begin
                if (fld_left.ok && fld_right.ok)
                begin
                    state_next = smooth_en_reg ? ST_MUL : ST_RECIP;
                    op_next    = smooth_en_reg ? OP_PREV : OP_TORQUE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_MUL:
            begin
                state_next = (op_reg == OP_PREV) ? ST_DIV_START : ST_SCALE;
            end
            ST_DIV_START:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_SLEW;
                end
            end
            ST_SLEW:
            begin
                state_next = ST_RECIP;
                op_next    = OP_TORQUE;
            end
            ST_RECIP:
            begin
                state_next = ST_REM;
            end
            ST_REM:
            begin
                state_next = ST_MUL;
            end
            ST_SCALE:
            begin
                case (op_reg)
                    OP_TORQUE:
                    begin
                        state_next = ST_RECIP;
                        op_next    = OP_DELAY;
                    end
                    default:
                    begin
                        if (motor_reg == MOTOR_LEFT)
                        begin
                            state_next = smooth_en_reg ? ST_MUL : ST_RECIP;
                            motor_next = MOTOR_RIGHT;
                            op_next    = smooth_en_reg ? OP_PREV : OP_TORQUE;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                endcase
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready      = (state_reg == ST_IDLE) && (slot_free || mid_cmd || move_last);
        div_req.start = (state_reg == ST_DIV_START);
        case (op_reg)
            OP_PREV:   div_req.len = DIV_LEN_SPEED;
            OP_TORQUE: div_req.len = DIV_LEN_TORQUE;
            default:   div_req.len = DIV_LEN_DELAY;
        endcase
        load_imm  = take && (((pos_reg == '0) && !is_letter)
                             || (!is_move_reg && (pos_reg == POS_W'(POWER_ARG_BYTES))));
        load_done = (state_reg == ST_DONE) && slot_free;
    end

    // ------------------------------------------------------------------
    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            op_reg          <= OP_PREV;
            motor_reg       <= MOTOR_LEFT;
            pos_reg         <= '0;
            is_move_reg     <= 1'b0;
            last_trq_reg[0] <= '0;
            last_trq_reg[1] <= '0;
            last_rev_reg[0] <= 1'b0;
            last_rev_reg[1] <= 1'b0;
            out_valid_reg   <= 1'b0;
            smooth_en_reg   <= RST_SMOOTH_EN;
            smooth_step_reg <= RST_SMOOTH_STEP;
            torque_min_reg  <= RST_TORQUE_MIN;
            torque_max_reg  <= RST_TORQUE_MAX;
            delay_min_reg   <= RST_DELAY_MIN;
            delay_max_reg   <= RST_DELAY_MAX;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            motor_reg <= motor_next;

            // byte position
            if (take)
            begin
                if (pos_reg == '0)
                begin
                    if (is_letter)
                    begin
                        is_move_reg <= (rx_byte == CHAR_M);
                        pos_reg     <= POS_W'(1);
                    end
                end
                else if (mid_cmd)
                begin
                    pos_reg <= pos_reg + 1'b1;
                end
                else
                begin
                    pos_reg <= '0;
                end
            end

            // remember what a successful move drove
            if (load_done && move_ok_reg)
            begin
                last_trq_reg[0] <= res_trq_reg[0];
                last_trq_reg[1] <= res_trq_reg[1];
                last_rev_reg[0] <= res_rev_reg[0];
                last_rev_reg[1] <= res_rev_reg[1];
            end

            // result slot
            if (load_imm || load_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SMOOTH_EN:   smooth_en_reg   <= cfg_data[0];
                    CFG_SMOOTH_STEP: smooth_step_reg <= cfg_data[7:0];
                    CFG_TORQUE_MIN:  torque_min_reg  <= cfg_data[15:0];
                    CFG_TORQUE_MAX:  torque_max_reg  <= cfg_data[15:0];
                    CFG_DELAY_MIN:   delay_min_reg   <= cfg_data;
                    CFG_DELAY_MAX:   delay_max_reg   <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        // argument bytes
        if (take && (pos_reg != '0))
        begin
            arg_reg[pos_m1[ARG_IDX_W-1:0]] <= rx_byte;
        end

        // parsed speeds
        if (state_reg == ST_PARSE)
        begin
            spd_reg[0]  <= $signed(fld_left.speed);
            spd_reg[1]  <= $signed(fld_right.speed);
            move_ok_reg <= fld_left.ok && fld_right.ok;
        end

        // product feeds the divider or the final scaling step
        if (state_reg == ST_MUL)
        begin
            prod_reg <= mul_p;
        end

        if (state_reg == ST_SLEW)
        begin
            spd_reg[motor_reg] <= slew_speed;
        end

        // range split into hundreds and remainder
        if (state_reg == ST_RECIP)
        begin
            qa_reg <= recip_p[63:RECIP_100_SHIFT];
        end

        if (state_reg == ST_REM)
        begin
            ra_reg <= ra_full[MAG_W-1:0];
            qm_reg <= 32'(qa_reg) * 32'(mag);
        end

        // previous speed from the divider
        if ((state_reg == ST_DIV_WAIT) && div_rsp.done)
        begin
            prev_reg <= prev_speed;
        end

        // scaled torque or delay
        if (state_reg == ST_SCALE)
        begin
            case (op_reg)
                OP_TORQUE:
                begin
                    res_trq_reg[motor_reg] <= torque_val;
                    res_rev_reg[motor_reg] <= cur_spd[7];
                end
                default:
                begin
                    res_dly_reg[motor_reg] <= delay_val;
                end
            endcase
        end

        // result payload
        if (load_imm)
        begin
            status_reg     <= imm_status;
            power_on_reg   <= (pos_reg != '0) && word_ena;
            out_rev_reg[0] <= 1'b0;
            out_rev_reg[1] <= 1'b0;
            out_trq_reg[0] <= '0;
            out_trq_reg[1] <= '0;
            out_dly_reg[0] <= '0;
            out_dly_reg[1] <= '0;
        end
        else if (load_done)
        begin
            status_reg     <= move_ok_reg ? STATUS_MOVE : STATUS_BAD_MOVE;
            power_on_reg   <= 1'b0;
            out_rev_reg[0] <= move_ok_reg && res_rev_reg[0];
            out_rev_reg[1] <= move_ok_reg && res_rev_reg[1];
            out_trq_reg[0] <= move_ok_reg ? res_trq_reg[0] : 16'd0;
            out_trq_reg[1] <= move_ok_reg ? res_trq_reg[1] : 16'd0;
            out_dly_reg[0] <= move_ok_reg ? res_dly_reg[0] : 32'd0;
            out_dly_reg[1] <= move_ok_reg ? res_dly_reg[1] : 32'd0;
        end
    end

    // ports
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign power_on      = power_on_reg;
    assign left_reverse  = out_rev_reg[MOTOR_LEFT];
    assign left_torque   = out_trq_reg[MOTOR_LEFT];
    assign left_delay    = out_dly_reg[MOTOR_LEFT];
    assign right_reverse = out_rev_reg[MOTOR_RIGHT];
    assign right_torque  = out_trq_reg[MOTOR_RIGHT];
    assign right_delay   = out_dly_reg[MOTOR_RIGHT];

    // ------------------------------------------------------------------
    // checks

    // the divider finishes only while the sequencer waits for it
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider done outside wait state");

    // the last move byte always starts the field check
    a_move_last_parse: assert property (@(posedge clk) disable iff (!rst_n)
        (take && move_last) |=> (state_reg == ST_PARSE))
        else $error("final move byte did not start the sequence");

    // motor fields are zero on any result other than a move
    a_motor_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != STATUS_MOVE)) |->
        ((left_torque == '0) && (right_torque == '0) && (left_delay == '0)
         && (right_delay == '0) && !left_reverse && !right_reverse))
        else $error("motor fields set on a non-move result");

    // slew limiting keeps speeds within full scale
    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |->
        ((cur_spd <= SPEED_FULL_SCALE) && (cur_spd >= -SPEED_FULL_SCALE)))
        else $error("speed out of range");

    // no input is taken while the sequencer is busy
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (div_rsp.busy || (state_reg == ST_PARSE)) |-> !in_ready)
        else $error("input accepted during a move computation");

endmodule
